FILE: design/fdl_pkg.sv
// Shared widths, defaults and register indexes for the fractional feedback delay line.
package fdl_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int DELAY_W       = 32;
    localparam int GAIN_W        = 16;
    localparam int RATE_W        = 18;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int FRAC_BITS     = 8;
    localparam int GAIN_FRAC     = 14;
    localparam int DEPTH_DEFAULT = 4096;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_INTERP_ENABLE = t_cfg_idx'(0);
    localparam t_cfg_idx REG_SAMPLE_RATE   = t_cfg_idx'(1);

endpackage

FILE: design/fdl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/fractional_feedback_delay_line.sv
// Fractional feedback delay line: top level with control sequencer and datapath.
//
// Usage: each input word carries one sample (Q1.23), a delay time in units of
// 2^-24 s and a feedback gain (Q2.14). The block answers every input word with
// exactly one output word holding the delayed sample, either the nearest lower
// stored sample or a linear interpolation with the following entry.
// Both data channels use valid and stall; a word moves on a rising edge with
// valid high and stall low. The configuration channel (valid, ready, index,
// data) is always ready; index 0 is the interpolation enable and index 1 the
// sample rate. Write it only while no word is in flight.
// Sequencing: a word is accepted only in the idle state; its result is loaded
// into the output register as the sequencer leaves its last state, and the
// next word can be taken in the cycle after that, so words never overlap.
// On the way it does one multiply for the delay, the position arithmetic,
// two reads of the single-read-port line memory, and two more multiplies
// (interpolation, feedback) with a rounding add between, each registered.
// Reset clears the write pointer and a wrap flag; entries not yet written since
// reset read as zero, so no clearing pass is needed. If the output register
// still holds an untaken word when the next result is ready, the sequencer
// waits in its last state, with input stall high, until the receiver takes it.
module fractional_feedback_delay_line #(
    parameter int DEPTH = fdl_pkg::DEPTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [fdl_pkg::DELAY_W-1:0]     i_delay_time,
    input  logic signed [fdl_pkg::GAIN_W-1:0]      i_feedback_gain,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [fdl_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    import fdl_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = AW + FRAC_BITS + 1;
    localparam int PROD_W = (DELAY_W - 1) + RATE_W;
    localparam int RAW_W  = PROD_W - 16;

    localparam logic [PW-1:0]    FULL     = PW'(DEPTH * 256);
    localparam logic [AW-1:0]    LAST     = AW'(DEPTH - 1);
    localparam logic signed [SB+2:0] SAT_HI = (SB+3)'((2 ** (SB - 1)) - 1);
    localparam logic signed [SB+2:0] SAT_LO = -SAT_HI - (SB+3)'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_POS,
        S_RDA,
        S_RDB,
        S_INT,
        S_SUM,
        S_FBM,
        S_WR
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic              r_interp;
    logic [RATE_W-1:0] r_rate;

    // Control state.
    logic [AW-1:0] r_widx;
    logic          r_wrapped;
    logic          r_out_valid;

    // Datapath registers.
    logic signed [SB-1:0]      r_x;
    logic signed [DELAY_W-1:0] r_t;
    logic signed [GAIN_W-1:0]  r_gain;
    logic [PROD_W-1:0]         r_prod;
    logic [PW-2:0]             r_rpos;
    logic [AW-1:0]             r_nxt;
    logic                      r_a_ok;
    logic                      r_b_ok;
    logic [FRAC_BITS-1:0]      r_frac;
    logic signed [SB-1:0]      r_a;
    logic signed [SB+9:0]      r_dprod;
    logic signed [SB-1:0]      r_s;
    logic signed [SB+15:0]     r_fprod;
    logic signed [SB-1:0]      r_out;

    // Combinational signals.
    logic [RAW_W-1:0]      delay_raw;
    logic [PW-1:0]         delay_c;
    logic [PW-1:0]         wq;
    logic [PW-1:0]         n_rpos;
    logic [AW-1:0]         ri;
    logic [AW-1:0]         ram_raddr;
    logic signed [SB-1:0]  ram_rdata;
    logic signed [SB-1:0]  b_val;
    logic signed [SB:0]    diff;
    logic signed [SB+9:0]  interp_sum;
    logic signed [SB+15:0] fb_round;
    logic signed [SB+1:0]  fb;
    logic signed [SB+2:0]  total;
    logic signed [SB-1:0]  n_store;
    logic                  out_free;
    logic                  do_write;
    logic                  positive_t;

    assign positive_t = !r_t[DELAY_W-1] && (r_t != '0);

    // Delay in samples with 8 fraction bits, limited to the line length.
    assign delay_raw = r_prod[PROD_W-1:16];
    assign delay_c   = (delay_raw > RAW_W'(FULL)) ? FULL : delay_raw[PW-1:0];
    assign wq        = {1'b0, r_widx, {FRAC_BITS{1'b0}}};
    assign n_rpos    = (wq >= delay_c) ? (wq - delay_c) : (wq + FULL - delay_c);

    assign ri        = r_rpos[AW+FRAC_BITS-1:FRAC_BITS];
    assign ram_raddr = (r_state == S_RDB) ? r_nxt : ri;

    // Entries beyond the fill point have never been written and read as zero.
    assign b_val = r_b_ok ? ram_rdata : '0;
    assign diff  = {b_val[SB-1], b_val} - {r_a[SB-1], r_a};

    assign interp_sum = {{2{r_a[SB-1]}}, r_a, {FRAC_BITS{1'b0}}} + r_dprod
                      + (SB+10)'(128);

    assign fb_round = r_fprod + (SB+16)'(8192);
    assign fb       = fb_round[SB+15:GAIN_FRAC];
    assign total    = {{3{r_x[SB-1]}}, r_x} + {fb[SB+1], fb};

    always_comb begin
        if (total > SAT_HI) begin
            n_store = SAT_HI[SB-1:0];
        end else if (total < SAT_LO) begin
            n_store = SAT_LO[SB-1:0];
        end else begin
            n_store = total[SB-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign do_write = (r_state == S_WR) && out_free;

    fdl_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_widx),
        .i_wdata (n_store),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interp    <= 1'b1;
            r_rate      <= RATE_RESET;
            r_widx      <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_INTERP_ENABLE: r_interp <= i_cfg_data[0];
                    REG_SAMPLE_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && !do_write) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample_in;
                        r_t     <= i_delay_time;
                        r_gain  <= i_feedback_gain;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= positive_t ? (r_t[DELAY_W-2:0] * r_rate) : '0;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_rpos  <= n_rpos[PW-2:0];
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    r_nxt   <= (ri == LAST) ? '0 : ri + AW'(1);
                    r_a_ok  <= r_wrapped || (ri < r_widx);
                    // The entry after the last one is entry 0.
                    r_b_ok  <= r_wrapped || ((ri == LAST) ? (r_widx != '0)
                                                          : ((ri + AW'(1)) < r_widx));
                    r_frac  <= r_interp ? r_rpos[FRAC_BITS-1:0] : '0;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_a     <= r_a_ok ? ram_rdata : '0;
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_dprod <= diff * $signed({1'b0, r_frac});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s     <= interp_sum[SB+FRAC_BITS-1:FRAC_BITS];
                    r_state <= S_FBM;
                end
                S_FBM: begin
                    r_fprod <= r_s * r_gain;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (out_free) begin
                        r_out       <= r_s;
                        r_out_valid <= 1'b1;
                        if (r_widx == LAST) begin
                            r_widx    <= '0;
                            r_wrapped <= 1'b1;
                        end else begin
                            r_widx <= r_widx + AW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;
    assign o_cfg_ready  = 1'b1;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the fractional feedback delay line.
`timescale 1ns / 1ps

module tb;

    import fdl_pkg::*;

    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int PHASE_WORDS   = 235;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PROBE_COUNT   = 19;
    localparam int PHASE_COUNT   = 8;

    localparam t_cfg_idx REG_SPARE = t_cfg_idx'(2);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DELAY_W-1:0]     delay_t;
    typedef logic signed [GAIN_W-1:0]      gain_t;
    typedef logic [RATE_W-1:0]             rate_t;

    localparam sample_t SMAX = 24'sh7FFFFF;
    localparam sample_t SMIN = 24'sh800000;
    localparam delay_t  DMAX = 32'sh7FFFFFFF;
    localparam delay_t  DMIN = 32'sh80000000;
    localparam gain_t   GMAX = 16'sh7FFF;
    localparam gain_t   GMIN = 16'sh8000;

    typedef struct packed {
        sample_t sample;
        delay_t  delay;
        gain_t   gain;
        logic    typed;
        sample_t want;
    } probe_t;

    typedef struct packed {
        logic  interp;
        rate_t rate;
        int    idle_pct;
        int    stall_pct;
    } phase_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    sample_t               i_sample_in;
    delay_t                i_delay_time;
    gain_t                 i_feedback_gain;
    logic                  o_out_valid;
    logic                  i_out_stall;
    sample_t               o_sample_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Mirror of the delay line, its write pointer and its registers.
    sample_t line_mem [DEPTH];
    int      write_ptr;
    logic    mirror_interp;
    rate_t   mirror_rate;

    sample_t echo_due [$];
    int      fault_count;
    int      cycle_count;
    int      tx_idle_pct;
    int      rx_stall_pct;

    probe_t  probe_rows [PROBE_COUNT];
    phase_t  phase_plan [PHASE_COUNT];

    fractional_feedback_delay_line #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_in    (i_sample_in),
        .i_delay_time   (i_delay_time),
        .i_feedback_gain(i_feedback_gain),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_out   (o_sample_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Computes the delayed sample for one word and writes input plus feedback into the mirror.
    function automatic sample_t predict_echo(sample_t x, delay_t t, gain_t g);
        longint full, lag, wq, rpos, ri, frac, nxt, a, b, s, fb, sum;
        full = longint'(DEPTH) << FRAC_BITS;
        lag  = 0;
        if (t > 0) begin
            lag = (longint'(t) * longint'(mirror_rate)) >>> 16;
            if (lag > full) begin
                lag = full;
            end
        end
        wq   = longint'(write_ptr) << FRAC_BITS;
        rpos = (wq >= lag) ? (wq - lag) : (wq + full - lag);
        if (rpos >= full) begin
            rpos = rpos - full;
        end
        ri   = rpos >>> FRAC_BITS;
        frac = rpos & 255;
        a    = line_mem[ri];
        if (mirror_interp) begin
            nxt = (ri < DEPTH - 1) ? ri + 1 : 0;
            b   = line_mem[nxt];
            s   = (a * (256 - frac) + b * frac + 128) >>> FRAC_BITS;
        end else begin
            s = a;
        end
        fb  = (s * longint'(g) + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        sum = longint'(x) + fb;
        if (sum > longint'(SMAX)) begin
            sum = longint'(SMAX);
        end else if (sum < longint'(SMIN)) begin
            sum = longint'(SMIN);
        end
        line_mem[write_ptr] = sample_t'(sum);
        write_ptr = (write_ptr == DEPTH - 1) ? 0 : write_ptr + 1;
        return sample_t'(s);
    endfunction

    // Offers one word and waits until it is taken. Called at a rising edge.
    task automatic push_word(input sample_t x, input delay_t t, input gain_t g,
                             input logic typed, input sample_t want);
        bit      idled;
        sample_t echo;
        idled = 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            if (!idled) begin
                i_in_valid <= 1'b0;
            end
            idled = 1'b1;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_in     <= x;
        i_delay_time    <= t;
        i_feedback_gain <= g;
        do @(posedge i_clk); while (o_in_stall);
        echo = predict_echo(x, t, g);
        echo_due.push_back(typed ? want : echo);
    endtask

    // Stops offering words, waits for every pending result and lets the block go quiet.
    task automatic settle_line();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (echo_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_INTERP_ENABLE) begin
            mirror_interp = data[0];
        end else if (idx == REG_SAMPLE_RATE) begin
            mirror_rate = data[RATE_W-1:0];
        end
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (echo_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected sample_out %0d with no word pending", o_sample_out);
                end
            end else if (o_sample_out !== echo_due[0]) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("sample_out mismatch: expected %0d, got %0d",
                             echo_due[0], o_sample_out);
                end
                void'(echo_due.pop_front());
            end else begin
                void'(echo_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fractional_feedback_delay_line verification failed");
            $finish;
        end
    end

    initial begin
        int      n, p, pick;
        longint  dq8, span;
        sample_t x;
        delay_t  t;
        gain_t   g;
        rate_t   rate_now;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_sample_in     <= '0;
        i_delay_time    <= '0;
        i_feedback_gain <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        fault_count   = 0;
        cycle_count   = 0;
        tx_idle_pct   = 13;
        rx_stall_pct  = 13;
        foreach (line_mem[i]) line_mem[i] = '0;
        write_ptr     = 0;
        mirror_interp = 1'b1;
        mirror_rate   = RATE_RESET;

        // Rows run at the reset settings: interpolation on, 48000 samples per second.
        // At that rate 350 time units give one sample of delay and 2797 give eight.
        probe_rows = '{
            '{SMAX,          32'sd0,       16'sd0,   1'b1, 24'sd0},
            // Negative delays read the slot about to be written.
            '{SMIN,          -32'sd1,      16'sd0,   1'b1, 24'sd0},
            '{24'sh123456,   DMIN,         16'sd0,   1'b1, 24'sd0},
            // A huge delay is held at the full line length.
            '{24'sd0,        DMAX,         16'sd0,   1'b1, 24'sd0},
            '{24'sh000400,   32'sd700,     GMAX,     1'b0, 24'sd0},
            '{-24'sd77,      32'sd525,     GMIN,     1'b0, 24'sd0},
            '{SMAX,          32'sd2,       GMAX,     1'b0, 24'sd0},
            // Half way between the last entry and entry 0.
            '{24'sd0,        32'sd2622,    16'sd0,   1'b1, 24'sd4194304},
            '{SMAX,          32'sd2797,    GMAX,     1'b1, SMAX},
            '{SMIN,          32'sd350,     GMIN,     1'b1, SMAX},
            '{SMAX,          32'sd350,     GMIN,     1'b1, SMIN},
            // Exactly the full line length, then one step short of it.
            '{24'sh2AAAAA,   32'sd1431656, 16'sh4000, 1'b1, 24'sd0},
            '{-24'sd1,       32'sd1431655, 16'sh4000, 1'b0, 24'sd0},
            '{24'sh555555,   32'sd1000,    16'sh2000, 1'b0, 24'sd0},
            '{24'sh7FFF00,   32'sd3000,    GMAX,     1'b0, 24'sd0},
            '{24'sh800100,   32'sd4000,    16'sh8001, 1'b0, 24'sd0},
            '{24'sh0000FF,   32'sd12345,   -16'sd3,  1'b0, 24'sd0},
            '{-24'sd4096,    32'sd5555,    16'sh0001, 1'b0, 24'sd0},
            '{24'sh00ABCD,   32'sd349,     16'sh3FFF, 1'b0, 24'sd0}
        };

        phase_plan = '{
            '{1'b1, rate_t'(48000),  0,  0},
            '{1'b0, rate_t'(48000),  61, 0},
            '{1'b1, rate_t'(262143), 0,  61},
            '{1'b0, rate_t'(1),      13, 13},
            '{1'b1, rate_t'(44100),  0,  0},
            '{1'b1, rate_t'(48000),  61, 0},
            '{1'b0, rate_t'(262143), 0,  61},
            '{1'b1, rate_t'(96000),  13, 13}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < PROBE_COUNT; n++) begin
            push_word(probe_rows[n].sample, probe_rows[n].delay, probe_rows[n].gain,
                      probe_rows[n].typed, probe_rows[n].want);
        end
        settle_line();

        for (p = 0; p < PHASE_COUNT; p++) begin
            rate_now = phase_plan[p].rate;
            if (p == 5) begin
                rate_now = rate_t'($urandom_range(2, 262142));
            end
            // Upper data bits are junk on purpose; only the register width counts.
            set_reg(REG_INTERP_ENABLE, ($urandom() & ~32'h1) | phase_plan[p].interp);
            set_reg(REG_SAMPLE_RATE, ($urandom() & ~32'h3FFFF) | rate_now);
            if (p == 3) begin
                set_reg(REG_SPARE, $urandom());
            end
            tx_idle_pct  = phase_plan[p].idle_pct;
            rx_stall_pct = phase_plan[p].stall_pct;

            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) begin
                    settle_line();
                end

                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    x = SMAX;
                end else if (pick < 20) begin
                    x = SMIN;
                end else if (pick < 30) begin
                    x = sample_t'(int'($urandom_range(0, 511)) - 256);
                end else begin
                    x = sample_t'($urandom());
                end

                // Mostly short delays so that recent feedback is read back.
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    dq8 = $urandom_range(0, 32 * 256);
                end else if (pick < 75) begin
                    dq8 = $urandom_range(0, DEPTH * 256);
                end else begin
                    dq8 = longint'(DEPTH) * 256 - 512 + $urandom_range(0, 1024);
                end
                if (pick < 85) begin
                    span = ((dq8 << 16) + $urandom_range(0, 65535)) / longint'(mirror_rate);
                    t = (span > longint'(DMAX)) ? DMAX : delay_t'(span);
                end else if (pick < 92) begin
                    t = delay_t'($urandom());
                end else if (pick < 96) begin
                    t = delay_t'({1'b1, 31'($urandom())});
                end else begin
                    t = '0;
                end

                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    g = gain_t'(int'($urandom_range(0, 29492)) - 14746);
                end else if (pick < 80) begin
                    g = gain_t'($urandom());
                end else if (pick < 90) begin
                    g = pick[0] ? GMAX : GMIN;
                end else begin
                    g = '0;
                end

                push_word(x, t, g, 1'b0, '0);
            end
            settle_line();
        end

        if (fault_count == 0) begin
            $display("fractional_feedback_delay_line verification clean");
        end else begin
            $display("fractional_feedback_delay_line verification failed");
        end
        $finish;
    end

endmodule
